### rtl/rped_pkg.sv
// ----------------------------------------------------------------------------
// RSA private exponent derivation package
// Shared widths, the controller state type, datapath operation codes and the
// status bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package rped_pkg;

  // Width of the shared divider and of the Bezout coefficient registers.
  localparam int unsigned DataW  = 64;
  // Width of the lcm and of the private exponent result.
  localparam int unsigned LamW   = 62;
  // Width of the public exponent register and of each prime field.
  localparam int unsigned ExpW   = 31;
  localparam int unsigned FieldW = 31;
  // Divider step counter width (DataW steps).
  localparam int unsigned CntW   = 6;

  localparam logic [ExpW-1:0] ExpReset = 31'd65537;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_LCM_WAIT,
    ST_EXT_INIT,
    ST_EXT_TEST,
    ST_EXT_WAIT,
    ST_RANGE,
    ST_MOD_WAIT,
    ST_EMIT
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ZERO_KEY,
    OP_GCD_INIT,
    OP_DIV_GCD,
    OP_GCD_STEP,
    OP_DIV_LCM,
    OP_LCM_MUL,
    OP_EXT_INIT,
    OP_DIV_EXT,
    OP_EXT_STEP,
    OP_FIX,
    OP_NEG_ZERO,
    OP_DIV_MOD,
    OP_MOD_STEP,
    OP_EMIT
  } op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_key;  // a prime of zero or one was given
    logic y_zero;    // current Euclid divisor is zero
    logic div_done;  // divider is idle
    logic d_neg;     // coefficient is negative
    logic d_ge_lam;  // coefficient is not below the lcm
  } dp_status_t;

endpackage

### rtl/rped_div.sv
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Produces one quotient bit per cycle, DataW quotient bits in all. Alongside, it forms
// the product of the quotient and a multiplicand, modulo 2^DataW, by shift
// and add on the quotient bits as they appear.
// ----------------------------------------------------------------------------
module rped_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rped_pkg::DataW-1:0] dividend_i,
  input  logic [rped_pkg::DataW-1:0] divisor_i,
  input  logic [rped_pkg::DataW-1:0] mult_i,
  output logic [rped_pkg::DataW-1:0] quo_o,
  output logic [rped_pkg::DataW-1:0] rem_o,
  output logic [rped_pkg::DataW-1:0] prod_o,
  output logic                       busy_o
);

  logic [rped_pkg::DataW-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [rped_pkg::DataW-1:0] prod_q, prod_d, mult_q, mult_d;
  logic [rped_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic [rped_pkg::DataW:0]   shifted, diff;
  logic                       qbit;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    shifted = {rem_q, quo_q[rped_pkg::DataW-1]};
    diff    = shifted - {1'b0, dsr_q};
    qbit    = ~diff[rped_pkg::DataW];
  end

  // Next state of the divider registers.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    prod_d = prod_q;
    mult_d = mult_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      prod_d = '0;
      mult_d = mult_i;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[rped_pkg::DataW-1:0] : shifted[rped_pkg::DataW-1:0];
      quo_d  = {quo_q[rped_pkg::DataW-2:0], qbit};
      prod_d = {prod_q[rped_pkg::DataW-2:0], 1'b0} + (qbit ? mult_q : '0);
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dsr_q  <= dsr_d;
    prod_q <= prod_d;
    mult_q <= mult_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign prod_o = prod_q;
  assign busy_o = busy_q;

endmodule

### rtl/rped_dp.sv
// ----------------------------------------------------------------------------
// RSA private exponent datapath
// Holds the Euclid operands, the Bezout coefficients, the lcm and the result
// register, and owns the shared divider. Every change is driven by one
// operation code from the controller.
// ----------------------------------------------------------------------------
module rped_dp #(
  parameter int unsigned PRIME_BITS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rped_pkg::op_e               op_i,
  input  logic [rped_pkg::FieldW-1:0] prime_p_i,
  input  logic [rped_pkg::FieldW-1:0] prime_q_i,
  input  logic [rped_pkg::ExpW-1:0]   exp_i,
  output rped_pkg::dp_status_t        status_o,
  output logic [rped_pkg::LamW-1:0]   private_exponent_o,
  output logic                        key_too_small_o,
  output logic                        not_invertible_o
);

  localparam int unsigned DW = rped_pkg::DataW;
  localparam int unsigned LW = rped_pkg::LamW;

  logic [PRIME_BITS-1:0] p_m, q_m;
  logic [PRIME_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [DW-1:0]         x_q, x_d, y_q, y_d, t_q, t_d, ot_q, ot_d;
  logic [LW-1:0]         lam_q, lam_d;
  logic                  bad_q, bad_d;
  logic [LW-1:0]         res_d_q, res_d_d;
  logic                  res_small_q, res_small_d, res_bad_q, res_bad_d;
  logic [2*PRIME_BITS-1:0] lcm_prod;

  logic          div_start;
  logic [DW-1:0] div_dvd, div_dsr, div_quo, div_rem, div_prod;
  logic          div_busy;

  assign p_m = prime_p_i[PRIME_BITS-1:0];
  assign q_m = prime_q_i[PRIME_BITS-1:0];

  // The lcm product, registered into lam_q.
  assign lcm_prod = div_quo[PRIME_BITS-1:0] * b_q;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = x_q;
    div_dsr   = y_q;
    case (op_i)
      rped_pkg::OP_DIV_GCD, rped_pkg::OP_DIV_EXT: begin
        div_start = 1'b1;
      end
      rped_pkg::OP_DIV_LCM: begin
        div_start = 1'b1;
        div_dvd   = DW'(a_q);
        div_dsr   = x_q;
      end
      rped_pkg::OP_DIV_MOD: begin
        div_start = 1'b1;
        div_dvd   = ot_q;
        div_dsr   = DW'(lam_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rped_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .mult_i     (t_q),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .prod_o     (div_prod),
    .busy_o     (div_busy)
  );

  // Register updates per operation.
  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    t_d         = t_q;
    ot_d        = ot_q;
    lam_d       = lam_q;
    bad_d       = bad_q;
    res_d_d     = res_d_q;
    res_small_d = res_small_q;
    res_bad_d   = res_bad_q;
    case (op_i)
      rped_pkg::OP_LOAD: begin
        // A prime of zero saturates p-1 at zero.
        a_d = (p_m == '0) ? '0 : p_m - 1'b1;
        b_d = (q_m == '0) ? '0 : q_m - 1'b1;
      end
      rped_pkg::OP_ZERO_KEY: begin
        lam_d = '0;
        ot_d  = '0;
        bad_d = 1'b1;
      end
      rped_pkg::OP_GCD_INIT: begin
        x_d = DW'(a_q);
        y_d = DW'(b_q);
      end
      rped_pkg::OP_GCD_STEP, rped_pkg::OP_MOD_STEP: begin
        if (op_i == rped_pkg::OP_GCD_STEP) begin
          x_d = y_q;
          y_d = div_rem;
        end else begin
          ot_d = div_rem;
        end
      end
      rped_pkg::OP_LCM_MUL: begin
        lam_d = LW'(lcm_prod);
      end
      rped_pkg::OP_EXT_INIT: begin
        x_d  = DW'(lam_q);
        y_d  = DW'(exp_i);
        t_d  = DW'(1);
        ot_d = '0;
      end
      rped_pkg::OP_EXT_STEP: begin
        x_d  = y_q;
        y_d  = div_rem;
        ot_d = t_q;
        t_d  = ot_q - div_prod;
      end
      rped_pkg::OP_FIX: begin
        bad_d = (x_q != DW'(1));
        ot_d  = ot_q[DW-1] ? ot_q + DW'(lam_q) : ot_q;
      end
      rped_pkg::OP_NEG_ZERO: begin
        ot_d = '0;
      end
      rped_pkg::OP_EMIT: begin
        res_d_d     = ot_q[LW-1:0];
        res_small_d = (lam_q <= LW'(exp_i));
        res_bad_d   = bad_q;
      end
      default: begin
        a_d = a_q;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    x_q         <= x_d;
    y_q         <= y_d;
    t_q         <= t_d;
    ot_q        <= ot_d;
    lam_q       <= lam_d;
    bad_q       <= bad_d;
    res_d_q     <= res_d_d;
    res_small_q <= res_small_d;
    res_bad_q   <= res_bad_d;
  end

  // Status back to the controller.
  always_comb begin
    status_o.zero_key = (a_q == '0) || (b_q == '0);
    status_o.y_zero   = (y_q == '0);
    status_o.div_done = ~div_busy;
    status_o.d_neg    = ot_q[DW-1];
    status_o.d_ge_lam = (ot_q >= DW'(lam_q));
  end

  assign private_exponent_o = res_d_q;
  assign key_too_small_o    = res_small_q;
  assign not_invertible_o   = res_bad_q;

endmodule

### rtl/rped_ctrl.sv
// ----------------------------------------------------------------------------
// RSA private exponent controller
// Sequences the gcd, the lcm, the extended Euclid loop and the final range
// correction, and manages the input and output handshakes.
// ----------------------------------------------------------------------------
module rped_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rped_pkg::dp_status_t status_i,
  output rped_pkg::op_e        op_o
);

  rped_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rped_pkg::ST_IDLE:     if (in_valid_i) state_d = rped_pkg::ST_CHECK;
      rped_pkg::ST_CHECK: begin
        state_d = status_i.zero_key ? rped_pkg::ST_EMIT : rped_pkg::ST_GCD_TEST;
      end
      rped_pkg::ST_GCD_TEST: begin
        state_d = status_i.y_zero ? rped_pkg::ST_LCM_WAIT : rped_pkg::ST_GCD_WAIT;
      end
      rped_pkg::ST_GCD_WAIT: if (status_i.div_done) state_d = rped_pkg::ST_GCD_TEST;
      rped_pkg::ST_LCM_WAIT: if (status_i.div_done) state_d = rped_pkg::ST_EXT_INIT;
      rped_pkg::ST_EXT_INIT: state_d = rped_pkg::ST_EXT_TEST;
      rped_pkg::ST_EXT_TEST: begin
        state_d = status_i.y_zero ? rped_pkg::ST_RANGE : rped_pkg::ST_EXT_WAIT;
      end
      rped_pkg::ST_EXT_WAIT: if (status_i.div_done) state_d = rped_pkg::ST_EXT_TEST;
      rped_pkg::ST_RANGE: begin
        if (!status_i.d_neg && status_i.d_ge_lam) state_d = rped_pkg::ST_MOD_WAIT;
        else                                      state_d = rped_pkg::ST_EMIT;
      end
      rped_pkg::ST_MOD_WAIT: if (status_i.div_done) state_d = rped_pkg::ST_EMIT;
      rped_pkg::ST_EMIT:     if (out_free) state_d = rped_pkg::ST_IDLE;
      default:               state_d = rped_pkg::ST_IDLE;
    endcase
  end

  // Outputs: datapath operation and input ready.
  always_comb begin
    op_o       = rped_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      rped_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = rped_pkg::OP_LOAD;
      end
      rped_pkg::ST_CHECK: begin
        op_o = status_i.zero_key ? rped_pkg::OP_ZERO_KEY : rped_pkg::OP_GCD_INIT;
      end
      rped_pkg::ST_GCD_TEST: begin
        op_o = status_i.y_zero ? rped_pkg::OP_DIV_LCM : rped_pkg::OP_DIV_GCD;
      end
      rped_pkg::ST_GCD_WAIT: if (status_i.div_done) op_o = rped_pkg::OP_GCD_STEP;
      rped_pkg::ST_LCM_WAIT: if (status_i.div_done) op_o = rped_pkg::OP_LCM_MUL;
      rped_pkg::ST_EXT_INIT: op_o = rped_pkg::OP_EXT_INIT;
      rped_pkg::ST_EXT_TEST: begin
        op_o = status_i.y_zero ? rped_pkg::OP_FIX : rped_pkg::OP_DIV_EXT;
      end
      rped_pkg::ST_EXT_WAIT: if (status_i.div_done) op_o = rped_pkg::OP_EXT_STEP;
      rped_pkg::ST_RANGE: begin
        if (status_i.d_neg)         op_o = rped_pkg::OP_NEG_ZERO;
        else if (status_i.d_ge_lam) op_o = rped_pkg::OP_DIV_MOD;
      end
      rped_pkg::ST_MOD_WAIT: if (status_i.div_done) op_o = rped_pkg::OP_MOD_STEP;
      rped_pkg::ST_EMIT:     if (out_free) op_o = rped_pkg::OP_EMIT;
      default:               op_o = rped_pkg::OP_NONE;
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (op_o == rped_pkg::OP_EMIT) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rped_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // An accepted item always starts at the key check.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rped_pkg::ST_CHECK))
    else $error("accepted item did not enter the key check");

  // A division that was just started is never reported finished.
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == rped_pkg::OP_DIV_GCD || op_o == rped_pkg::OP_DIV_EXT ||
     op_o == rped_pkg::OP_DIV_LCM || op_o == rped_pkg::OP_DIV_MOD)
    |=> !status_i.div_done)
    else $error("divider reported done right after start");

  // Loading a result always raises the output valid.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == rped_pkg::OP_EMIT) |=> out_valid_q)
    else $error("result loaded without output valid");
`endif

endmodule

### rtl/rsa_private_exponent_derive_unit.sv
// The Euclid steps share the radix-2 divider, one quotient bit per cycle; a
// prime of zero or one goes straight to the result, other items run the gcd,
// the lcm division, the extended Euclid loop and the final reduction.
// Throughput: one item at a time; the next item is taken once the result
// sits in the output register. Reset is asynchronous and active low; it
// clears the controller and loads the exponent register with 65537.
// ----------------------------------------------------------------------------
// RSA private exponent derivation unit
// Forms L = lcm(p-1, q-1) and returns d = e^-1 mod L with small-key and
// non-invertible flags; e is set through the register port.
// ----------------------------------------------------------------------------
module rsa_private_exponent_derive_unit #(
  parameter int unsigned PRIME_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // prime_p [30:0], prime_q [61:31], zero pad
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // private_exponent [61:0], zero pad
  output logic [1:0]  m_axis_tuser_o,   // key_too_small [0], not_invertible [1]
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] AddrExp = 3'd0;

  logic [rped_pkg::ExpW-1:0] exp_q, exp_d;
  rped_pkg::op_e             op;
  rped_pkg::dp_status_t      status;
  logic [rped_pkg::LamW-1:0] priv_exp;
  logic                      key_small, not_inv;

  // Public exponent register.
  always_comb begin
    exp_d = exp_q;
    if (psel && penable && pwrite && paddr == AddrExp) exp_d = pwdata[rped_pkg::ExpW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= rped_pkg::ExpReset;
    end else begin
      exp_q <= exp_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrExp) ? {1'b0, exp_q} : '0;

  rped_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .op_o        (op)
  );

  rped_dp #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .prime_p_i          (s_axis_tdata_i[30:0]),
    .prime_q_i          (s_axis_tdata_i[61:31]),
    .exp_i              (exp_q),
    .status_o           (status),
    .private_exponent_o (priv_exp),
    .key_too_small_o    (key_small),
    .not_invertible_o   (not_inv)
  );

  assign m_axis_tdata_o = {2'b00, priv_exp};
  assign m_axis_tuser_o = {not_inv, key_small};

endmodule
